[rtl/chc_pkg.sv]
// Package for the compass heading block: shared constants, the arctangent table
// and the configuration register codes. No dependencies.
`default_nettype none

package chc_pkg;

    localparam int ATAN_TABLE_LEN = 24;
    localparam int XY_W           = 28;
    localparam int Z_W            = 33;
    localparam int HEAD_W         = 18;

    localparam logic signed [Z_W-1:0]    C_QUARTER_Q16 = 33'sd589824000;
    localparam logic signed [Z_W-1:0]    C_HALF_LSB    = 33'sd32768;
    localparam logic signed [HEAD_W-1:0] C_FULL_TURN   = 18'sd36000;

    typedef enum logic [1:0] {
        CFG_X_OFFSET = 2'd0,
        CFG_Y_OFFSET = 2'd1,
        CFG_DECL     = 2'd2
    } t_cfg_idx;

    function automatic logic [31:0] chc_atan_q16(input logic [4:0] i_idx);
        logic [31:0] v;
        unique case (i_idx)
            5'd0:  v = 32'd294912000;
            5'd1:  v = 32'd174096719;
            5'd2:  v = 32'd91987925;
            5'd3:  v = 32'd46694507;
            5'd4:  v = 32'd23437865;
            5'd5:  v = 32'd11730358;
            5'd6:  v = 32'd5866610;
            5'd7:  v = 32'd2933484;
            5'd8:  v = 32'd1466764;
            5'd9:  v = 32'd733385;
            5'd10: v = 32'd366693;
            5'd11: v = 32'd183346;
            5'd12: v = 32'd91673;
            5'd13: v = 32'd45837;
            5'd14: v = 32'd22918;
            5'd15: v = 32'd11459;
            5'd16: v = 32'd5730;
            5'd17: v = 32'd2865;
            5'd18: v = 32'd1432;
            5'd19: v = 32'd716;
            5'd20: v = 32'd358;
            5'd21: v = 32'd179;
            5'd22: v = 32'd90;
            5'd23: v = 32'd45;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/chc_if.sv]
// Request and result channel interfaces of the compass heading block.
// Valid/ready handshake with the sample bytes or the result fields as payload.
`default_nettype none

interface chc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;
    logic       complete;

    modport source (
        output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte, complete,
        input  ready
    );
    modport sink (
        input  valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte, complete,
        output ready
    );
endinterface

interface chc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_field;
    logic signed [15:0] y_field;
    logic signed [15:0] z_field;
    logic        [15:0] heading;
    logic               valid_res;

    modport source (
        output valid, x_field, y_field, z_field, heading, valid_res,
        input  ready
    );
    modport sink (
        input  valid, x_field, y_field, z_field, heading, valid_res,
        output ready
    );
endinterface

`default_nettype wire

[rtl/chc_cordic.sv]
// Iterative vectoring CORDIC: atan2 of two 17-bit values in centidegrees.
// One micro-rotation per cycle on a shared shift/add unit; uses chc_pkg.
`default_nettype none

module chc_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [16:0] i_xc,
    input  wire logic signed [16:0] i_yc,
    output logic                    o_done,
    output logic signed [16:0]      o_angle
);
    import chc_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
    localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam logic [CW-1:0] LAST = CW'(NSTEP - 1);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_zero;
    logic [CW-1:0]           r_cnt;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;

    logic signed [XY_W-1:0]  x0;
    logic signed [XY_W-1:0]  y0;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [Z_W-1:0]   step_ang;
    logic signed [Z_W-1:0]   z_round;

    assign x0       = {{3{i_xc[16]}}, i_xc, 8'b0};
    assign y0       = {{3{i_yc[16]}}, i_yc, 8'b0};
    assign dx       = r_y >>> r_cnt;
    assign dy       = r_x >>> r_cnt;
    assign step_ang = signed'({1'b0, chc_atan_q16(5'(r_cnt))});
    assign z_round  = r_z + C_HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_zero <= (i_xc == 17'sd0) && (i_yc == 17'sd0);
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        r_x <= y0;
                        r_y <= -x0;
                        r_z <= C_QUARTER_Q16;
                    end else begin
                        r_x <= -y0;
                        r_y <= x0;
                        r_z <= -C_QUARTER_Q16;
                    end
                end else begin
                    r_x <= x0;
                    r_y <= y0;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + step_ang;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - step_ang;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? 17'sd0 : signed'(z_round[32:16]);

endmodule

`default_nettype wire

[rtl/compass_heading_from_magnetometer.sv]
// Compass heading from one magnetometer sample: byte packing, hard-iron offsets,
// CORDIC atan2, declination and wrap into 0..35999. Uses chc_pkg, chc_if, chc_cordic.
// A complete sample passes through the one-rotation-per-cycle CORDIC loop, the declination add
// and up to two wrap corrections in S_WRAP; a short sample goes straight to S_SEND.
// Throughput: one request at a time; S_SEND waits for a free output slot before the next.
// Reset (synchronous, active low): offsets, declination and held values cleared.
`default_nettype none

module compass_heading_from_magnetometer #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    chc_in_if.sink           i_in,
    chc_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import chc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ATAN,
        S_WRAP,
        S_SEND
    } t_state;

    t_state                  r_state;
    logic signed [15:0]      r_x_offset;
    logic signed [15:0]      r_y_offset;
    logic signed [15:0]      r_decl;
    logic signed [15:0]      r_held_x;
    logic signed [15:0]      r_held_y;
    logic signed [15:0]      r_held_z;
    logic [15:0]             r_held_heading;
    logic signed [HEAD_W-1:0] r_h;
    logic                    r_vres;
    logic                    r_ovalid;
    logic signed [15:0]      r_out_x;
    logic signed [15:0]      r_out_y;
    logic signed [15:0]      r_out_z;
    logic [15:0]             r_out_heading;
    logic                    r_out_vres;

    logic                    accept;
    logic                    start;
    logic signed [15:0]      raw_x;
    logic signed [15:0]      raw_y;
    logic signed [15:0]      raw_z;
    logic signed [16:0]      xc;
    logic signed [16:0]      yc;
    logic                    cordic_done;
    logic signed [16:0]      angle;
    logic signed [HEAD_W-1:0] head_sum;

    assign accept = i_in.valid && i_in.ready;
    assign start  = accept && i_in.complete;
    assign raw_x  = signed'({i_in.x_high_byte, i_in.x_low_byte});
    assign raw_y  = signed'({i_in.y_high_byte, i_in.y_low_byte});
    assign raw_z  = signed'({i_in.z_high_byte, i_in.z_low_byte});
    assign xc     = {raw_x[15], raw_x} - {r_x_offset[15], r_x_offset};
    assign yc     = {raw_y[15], raw_y} - {r_y_offset[15], r_y_offset};
    assign head_sum = {angle[16], angle} + {{2{r_decl[15]}}, r_decl};

    chc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_xc    (xc),
        .i_yc    (yc),
        .o_done  (cordic_done),
        .o_angle (angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset <= '0;
            r_y_offset <= '0;
            r_decl     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_OFFSET: r_x_offset <= i_cfg_data;
                CFG_Y_OFFSET: r_y_offset <= i_cfg_data;
                CFG_DECL:     r_decl     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ovalid       <= 1'b0;
            r_held_x       <= '0;
            r_held_y       <= '0;
            r_held_z       <= '0;
            r_held_heading <= '0;
        end else begin
            if (o_out.ready && (r_state != S_SEND)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_vres <= i_in.complete;
                        if (i_in.complete) begin
                            r_held_x <= raw_x;
                            r_held_y <= raw_y;
                            r_held_z <= raw_z;
                            r_state  <= S_ATAN;
                        end else begin
                            r_h     <= signed'({2'b00, r_held_heading});
                            r_state <= S_SEND;
                        end
                    end
                end
                S_ATAN: begin
                    if (cordic_done) begin
                        r_h     <= head_sum;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_h < 0) begin
                        r_h <= r_h + C_FULL_TURN;
                    end else if (r_h >= C_FULL_TURN) begin
                        r_h <= r_h - C_FULL_TURN;
                    end else begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid       <= 1'b1;
                        r_out_x        <= r_held_x;
                        r_out_y        <= r_held_y;
                        r_out_z        <= r_held_z;
                        r_out_heading  <= r_h[15:0];
                        r_out_vres     <= r_vres;
                        r_held_heading <= r_h[15:0];
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.x_field   = r_out_x;
    assign o_out.y_field   = r_out_y;
    assign o_out.z_field   = r_out_z;
    assign o_out.heading   = r_out_heading;
    assign o_out.valid_res = r_out_vres;

endmodule

`default_nettype wire
